// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define RHSV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rhsv assertion failed");

// Checked during reset as well.
`define RHSV_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rhsv reset assertion failed");

`endif

// ===== rtl/rhsv_pkg.sv =====
package rhsv_pkg;

  localparam int CH_W   = 8;
  localparam int HUE_W  = 9;
  localparam int SAT_W  = 9;
  localparam int QUO_W  = 9;
  localparam int MUL_W  = 6;
  localparam int PROD_W = CH_W + MUL_W;

  localparam logic [MUL_W-1:0]        HUE_SEXTANT    = 6'd43;
  localparam logic signed [HUE_W-1:0] HUE_RED_BASE   = 9'sd0;
  localparam logic signed [HUE_W-1:0] HUE_GREEN_BASE = 9'sd85;
  localparam logic signed [HUE_W-1:0] HUE_BLUE_BASE  = 9'sd171;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } sel_t;

  typedef struct packed {
    logic [CH_W-1:0] mx;
    sel_t            sel;
    logic            neg;
    logic            grey;
  } side_t;

endpackage

// ===== rtl/rgb_to_hsv_byte_hue.sv =====
// RGB to HSV, byte-scale hue.
// Stages from accepted request to out_valid: 2 prep stages, 9 stages of
// bit-per-stage restoring division, 1 output register.
// Throughput: one pixel per cycle while in_stall is low; each stage holds while its successor is full
// and stalled, so in_stall follows out_stall only when every stage is full.
// Reset (rst_n low, synchronous) clears all stage valid bits; no data is reset.
module rgb_to_hsv_byte_hue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rhsv_pkg::CH_W-1:0]          in_red,
  input  logic [rhsv_pkg::CH_W-1:0]          in_green,
  input  logic [rhsv_pkg::CH_W-1:0]          in_blue,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rhsv_pkg::HUE_W-1:0]  out_hue,
  output logic [rhsv_pkg::SAT_W-1:0]         out_saturation,
  output logic [rhsv_pkg::CH_W-1:0]          out_brightness
);

  localparam int CH_W  = rhsv_pkg::CH_W;
  localparam int QUO_W = rhsv_pkg::QUO_W;
  localparam int DIV_W = CH_W + QUO_W;
  localparam int NSTG  = QUO_W + 3;
  localparam int DIV0  = 2;
  localparam int OSTG  = NSTG - 1;

  logic [NSTG-1:0] valid_r;
  logic [NSTG-1:0] valid_nxt;
  logic [NSTG-1:0] ld;

  always_comb begin
    ld[OSTG] = !valid_r[OSTG] || !out_stall;
    for (int k = OSTG - 1; k >= 0; k--) begin
      ld[k] = !valid_r[k] || ld[k+1];
    end
    valid_nxt[0] = ld[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NSTG; k++) begin
      if (ld[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall = !ld[0];

  // stage A: max, min, largest channel, signed difference
  logic [CH_W-1:0]   a_mx_r, a_mx_nxt;
  logic [CH_W-1:0]   a_mn_r, a_mn_nxt;
  rhsv_pkg::sel_t    a_sel_r, a_sel_nxt;
  logic signed [CH_W:0] a_diff_r, a_diff_nxt;

  always_comb begin
    a_mn_nxt = (in_red < in_green) ? in_red : in_green;
    if (in_blue < a_mn_nxt) begin
      a_mn_nxt = in_blue;
    end
    if (in_red >= in_green && in_red >= in_blue) begin
      a_sel_nxt  = rhsv_pkg::SEL_RED;
      a_mx_nxt   = in_red;
      a_diff_nxt = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
    end else if (in_green >= in_blue) begin
      a_sel_nxt  = rhsv_pkg::SEL_GREEN;
      a_mx_nxt   = in_green;
      a_diff_nxt = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
    end else begin
      a_sel_nxt  = rhsv_pkg::SEL_BLUE;
      a_mx_nxt   = in_blue;
      a_diff_nxt = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a_mx_r   <= a_mx_nxt;
      a_mn_r   <= a_mn_nxt;
      a_sel_r  <= a_sel_nxt;
      a_diff_r <= a_diff_nxt;
    end
  end

  // stage B: delta, |diff| * 43
  logic [CH_W-1:0]             b_delta_r, b_delta_nxt;
  logic [rhsv_pkg::PROD_W-1:0] b_prod_r, b_prod_nxt;
  rhsv_pkg::side_t             b_side_r, b_side_nxt;
  logic [CH_W-1:0]             a_abs;

  always_comb begin
    a_abs            = a_diff_r[CH_W] ? CH_W'(-a_diff_r) : a_diff_r[CH_W-1:0];
    b_delta_nxt      = a_mx_r - a_mn_r;
    b_prod_nxt       = a_abs * rhsv_pkg::HUE_SEXTANT;
    b_side_nxt.mx    = a_mx_r;
    b_side_nxt.sel   = a_sel_r;
    b_side_nxt.neg   = a_diff_r[CH_W];
    b_side_nxt.grey  = (a_mx_r == a_mn_r);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      b_delta_r <= b_delta_nxt;
      b_prod_r  <= b_prod_nxt;
      b_side_r  <= b_side_nxt;
    end
  end

  // dividers: saturation = delta*256/max, hue part = 43*|diff|/delta
  logic [QUO_W-1:0] sat_q;
  logic [QUO_W-1:0] hue_q;

  rhsv_div #(
    .DEN_W(CH_W),
    .QUO_W(QUO_W)
  ) u_sat_div (
    .clk(clk),
    .adv(ld[DIV0+QUO_W-1:DIV0]),
    .num(DIV_W'({b_delta_r, 8'h00})),
    .den(b_side_r.mx),
    .quo(sat_q)
  );

  rhsv_div #(
    .DEN_W(CH_W),
    .QUO_W(QUO_W)
  ) u_hue_div (
    .clk(clk),
    .adv(ld[DIV0+QUO_W-1:DIV0]),
    .num(DIV_W'(b_prod_r)),
    .den(b_delta_r),
    .quo(hue_q)
  );

  rhsv_pkg::side_t side_r [QUO_W];

  always_ff @(posedge clk) begin
    if (ld[DIV0]) begin
      side_r[0] <= b_side_r;
    end
    for (int i = 1; i < QUO_W; i++) begin
      if (ld[DIV0+i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // output register
  logic signed [rhsv_pkg::HUE_W-1:0] hue_r, hue_nxt;
  logic [rhsv_pkg::SAT_W-1:0]        sat_r, sat_nxt;
  logic [CH_W-1:0]                   bright_r;
  logic signed [rhsv_pkg::HUE_W-1:0] hue_base;
  logic signed [rhsv_pkg::HUE_W-1:0] hue_part;
  rhsv_pkg::side_t                   d_side;

  always_comb begin
    d_side   = side_r[QUO_W-1];
    hue_part = d_side.neg ? -$signed(hue_q) : $signed(hue_q);
    case (d_side.sel)
      rhsv_pkg::SEL_RED:   hue_base = rhsv_pkg::HUE_RED_BASE;
      rhsv_pkg::SEL_GREEN: hue_base = rhsv_pkg::HUE_GREEN_BASE;
      rhsv_pkg::SEL_BLUE:  hue_base = rhsv_pkg::HUE_BLUE_BASE;
      default:             hue_base = rhsv_pkg::HUE_RED_BASE;
    endcase
    if (d_side.grey) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      hue_nxt = hue_base + hue_part;
      sat_nxt = sat_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[OSTG]) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= d_side.mx;
    end
  end

  assign out_valid      = valid_r[OSTG];
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

endmodule

// ===== rtl/rhsv_div.sv =====
module rhsv_div #(
  parameter int DEN_W = rhsv_pkg::CH_W,
  parameter int QUO_W = rhsv_pkg::QUO_W
) (
  input  logic                   clk,
  input  logic [QUO_W-1:0]       adv,
  input  logic [DEN_W+QUO_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic [QUO_W-1:0]       quo
);

  localparam int W = DEN_W + QUO_W;

  logic [W-1:0]     rem_r [QUO_W-1];
  logic [DEN_W-1:0] den_r [QUO_W-1];
  logic [QUO_W-1:0] quo_r [QUO_W];

  // one quotient bit per stage, MSB first
  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    localparam int B = QUO_W - 1 - i;
    logic [W-1:0]     rem_in;
    logic [W-1:0]     shd;
    logic [W-1:0]     rem_nxt;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [QUO_W-1:0] quo_nxt;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    assign shd = W'(den_in) << B;

    always_comb begin
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      if (rem_in >= shd) begin
        rem_nxt    = rem_in - shd;
        quo_nxt[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i]) begin
        quo_r[i] <= quo_nxt;
      end
    end

    if (i < QUO_W - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (adv[i]) begin
          rem_r[i] <= rem_nxt;
          den_r[i] <= den_in;
        end
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

// ===== rtl/rhsv_chk.sv =====
`include "assert_macros.svh"

module rhsv_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [rhsv_pkg::HUE_W-1:0]  out_hue,
  input logic [rhsv_pkg::SAT_W-1:0]         out_saturation,
  input logic [rhsv_pkg::CH_W-1:0]          out_brightness
);

  property p_hold;
    out_valid && out_stall |=> out_valid && $stable(out_hue) &&
      $stable(out_saturation) && $stable(out_brightness);
  endproperty

  property p_range;
    out_valid |-> out_saturation <= 9'd256 && out_hue >= -9'sd43 &&
      out_hue <= 9'sd214;
  endproperty

  `RHSV_ASSERT_RST(a_rst_clears, !rst_n |=> !out_valid)
  `RHSV_ASSERT(a_hold, p_hold)
  `RHSV_ASSERT(a_black, out_valid && out_brightness == '0 |-> out_hue == '0 && out_saturation == '0)
  `RHSV_ASSERT(a_grey, out_valid && out_saturation == '0 |-> out_hue == '0)
  `RHSV_ASSERT(a_range, p_range)

endmodule

bind rgb_to_hsv_byte_hue rhsv_chk u_rhsv_chk (.*);
